// ===== src/codb_pkg.sv =====
// ----------------------------------------------------------------------------
// codb_pkg: shared types and codes for the causal-order delivery buffer
// Holds the input request layout and the result status codes.
// ----------------------------------------------------------------------------
package codb_pkg;

    localparam int NUM_PROCS = 3;
    localparam int IN_CLK_W  = 16;
    localparam int TAG_W     = 8;
    localparam int STATUS_W  = 2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DELIVERED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_HELD      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DROPPED   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNUSED    = 2'd3;

    // One request as it arrives on tdata, last field (c0) in the lowest bits
    typedef struct packed {
        logic [TAG_W-1:0]    tag;
        logic [IN_CLK_W-1:0] c2;
        logic [IN_CLK_W-1:0] c1;
        logic [IN_CLK_W-1:0] c0;
    } codb_item_t;

endpackage

// ===== src/causal_order_delivery_buffer.sv =====
// ----------------------------------------------------------------------------
// causal_order_delivery_buffer: causal-order delivery with a vector clock
// Front intake queue feeding a delivery sequencer with a held-message store.
// ----------------------------------------------------------------------------
// Usage
//   Input stream s_axis: each request carries a three-entry vector clock
//   and a message tag. A request that is causally ready is delivered at
//   once, then the held store is drained oldest first while any entry is
//   ready. A request that is not ready is held, or dropped when the store
//   is full.
//   Output stream m_axis: one result per delivered, held or dropped
//   message; tlast marks the final result caused by a request.
// Sequencing
//   A held or dropped request goes from the evaluate step to the output
//   register. A delivered request is followed by a scan of the held entries
//   one per step; each drained entry is removed by moving later entries up one
//   at a time, then a fresh scan. The single-port memory sets this pace, and a
//   new request is taken only once the last one and its drain are done.
// Reset
//   Clears the vector clock, the held count and both queues. The store
//   itself needs no clearing: only entries below the count are read.
// Stalls
//   While tready is low the result stays in the output register and the
//   sequencer holds before the next load; the intake queue takes up to two requests.
// ----------------------------------------------------------------------------
module causal_order_delivery_buffer
    import codb_pkg::*;
#(
    parameter int BUFFER_DEPTH = 16,
    parameter int CLOCK_WIDTH  = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // clock_0[15:0], clock_1, clock_2, msg_tag[7:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_tag[7:0]
    output logic [2:0]  m_axis_tuser,   // status[1:0], from_buffer
    output logic        m_axis_tlast    // last
);

    codb_item_t item;
    logic       item_valid;
    logic       item_pop;

    // Intake: queue requests so the stream side need not wait on a drain step while the queue has room
    codb_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .item          (item),
        .item_valid    (item_valid),
        .item_pop      (item_pop)
    );

    // Sequencer: deliver, hold, drop and drain
    codb_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .CLOCK_WIDTH  (CLOCK_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .item_valid    (item_valid),
        .item_pop      (item_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== src/codb_front.sv =====
// ----------------------------------------------------------------------------
// codb_front: request intake
// Accept requests from the stream and hold them in a two-entry queue.
// ----------------------------------------------------------------------------
module codb_front
    import codb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [55:0] s_axis_tdata,
    output codb_item_t item,
    output logic       item_valid,
    input  logic       item_pop
);

    codb_item_t q_reg [2];
    logic [1:0] cnt_reg;
    logic       wp_reg;
    logic       rp_reg;
    logic       push;
    logic       pop;

    assign s_axis_tready = (cnt_reg != 2'd2);
    assign item_valid    = (cnt_reg != 2'd0);
    assign item          = q_reg[rp_reg];
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = item_pop && item_valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= codb_item_t'(s_axis_tdata);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= !wp_reg;
            end
            if (pop)
            begin
                rp_reg <= !rp_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

// ===== src/codb_back.sv =====
// ----------------------------------------------------------------------------
// codb_back: delivery sequencer
// Test each request against the current vector; deliver, hold or drop it, and
// drain the held store one entry per step through a single-port memory.
// ----------------------------------------------------------------------------
module codb_back
    import codb_pkg::*;
#(
    parameter int BUFFER_DEPTH = 16,
    parameter int CLOCK_WIDTH  = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  codb_item_t          item,
    input  logic                item_valid,
    output logic                item_pop,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [7:0]          m_axis_tdata,
    output logic [2:0]          m_axis_tuser,
    output logic                m_axis_tlast
);

    localparam int CW   = CLOCK_WIDTH;
    localparam int AW   = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CNTW = $clog2(BUFFER_DEPTH + 1);
    localparam int EW   = NUM_PROCS * CW + TAG_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_CHK   = 3'd3;
    localparam logic [2:0] S_SHIFT = 3'd4;
    localparam logic [2:0] S_SHW   = 3'd5;

    logic [2:0]      state_reg;
    logic [CW-1:0]   cur_reg    [NUM_PROCS];
    logic [CW-1:0]   work_c_reg [NUM_PROCS];
    logic [TAG_W-1:0] work_tag_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [CNTW-1:0] idx_reg;
    logic [CNTW-1:0] k_reg;
    logic [TAG_W-1:0] pend_tag_reg;
    logic            pend_fb_reg;
    logic            out_valid_reg;
    logic [TAG_W-1:0] out_tag_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic            out_fb_reg;
    logic            out_last_reg;

    logic [EW-1:0]   mem [BUFFER_DEPTH];
    logic [EW-1:0]   rd_q;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [EW-1:0]   wr_data;

    logic [CW-1:0]   mem_c [NUM_PROCS];
    logic [TAG_W-1:0] mem_tag;
    logic [CW-1:0]   max_work [NUM_PROCS];
    logic [CW-1:0]   max_mem  [NUM_PROCS];
    logic            dlv_work;
    logic            dlv_mem;
    logic            out_free;
    logic            out_load;
    logic            has_room;
    logic [CNTW-1:0] kp1;

    function automatic logic can_deliver(input logic [CW-1:0] c0, input logic [CW-1:0] c1,
                                         input logic [CW-1:0] c2, input logic [CW-1:0] r0,
                                         input logic [CW-1:0] r1, input logic [CW-1:0] r2);
        logic [CW:0] n0;
        logic [CW:0] n1;
        logic [CW:0] n2;
        logic        e0;
        logic        e1;
        logic        e2;
        logic        gt;
        n0 = {1'b0, r0} + {{CW{1'b0}}, 1'b1};
        n1 = {1'b0, r1} + {{CW{1'b0}}, 1'b1};
        n2 = {1'b0, r2} + {{CW{1'b0}}, 1'b1};
        gt = ({1'b0, c0} > n0) || ({1'b0, c1} > n1) || ({1'b0, c2} > n2);
        e0 = ({1'b0, c0} == n0);
        e1 = ({1'b0, c1} == n1);
        e2 = ({1'b0, c2} == n2);
        return !gt && !((e0 && e1) || (e0 && e2) || (e1 && e2));
    endfunction

    always_comb
    begin
        for (int i = 0; i < NUM_PROCS; i++)
        begin
            mem_c[i]    = rd_q[i*CW +: CW];
            max_work[i] = (work_c_reg[i] > cur_reg[i]) ? work_c_reg[i] : cur_reg[i];
            max_mem[i]  = (mem_c[i] > cur_reg[i]) ? mem_c[i] : cur_reg[i];
        end
    end

    assign mem_tag  = rd_q[EW-1 -: TAG_W];
    assign dlv_work = can_deliver(work_c_reg[0], work_c_reg[1], work_c_reg[2],
                                  cur_reg[0], cur_reg[1], cur_reg[2]);
    assign dlv_mem  = can_deliver(mem_c[0], mem_c[1], mem_c[2],
                                  cur_reg[0], cur_reg[1], cur_reg[2]);
    assign out_free = !out_valid_reg || m_axis_tready;
    assign has_room = (cnt_reg < CNTW'(BUFFER_DEPTH));
    assign kp1      = k_reg + CNTW'(1);
    assign item_pop = (state_reg == S_IDLE) && item_valid;

    // Load the output register this cycle
    assign out_load = out_free && (((state_reg == S_EVAL) && !dlv_work)
                                || ((state_reg == S_SCAN) && (idx_reg == cnt_reg))
                                || ((state_reg == S_CHK) && dlv_mem));

    // Memory port control
    always_comb
    begin
        rd_en   = ((state_reg == S_SCAN) && (idx_reg != cnt_reg))
               || ((state_reg == S_SHIFT) && (kp1 != cnt_reg));
        rd_addr = (state_reg == S_SCAN) ? idx_reg[AW-1:0] : kp1[AW-1:0];
        wr_en   = ((state_reg == S_EVAL) && !dlv_work && out_free && has_room)
               || (state_reg == S_SHW);
        wr_addr = (state_reg == S_EVAL) ? cnt_reg[AW-1:0] : k_reg[AW-1:0];
        wr_data = (state_reg == S_EVAL)
                ? {work_tag_reg, work_c_reg[2], work_c_reg[1], work_c_reg[0]} : rd_q;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            idx_reg        <= '0;
            k_reg          <= '0;
            out_valid_reg  <= 1'b0;
            out_tag_reg    <= '0;
            out_status_reg <= ST_DELIVERED;
            out_fb_reg     <= 1'b0;
            out_last_reg   <= 1'b0;
            pend_tag_reg   <= '0;
            pend_fb_reg    <= 1'b0;
            work_tag_reg   <= '0;
            for (int i = 0; i < NUM_PROCS; i++)
            begin
                cur_reg[i]    <= '0;
                work_c_reg[i] <= '0;
            end
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        work_c_reg[0] <= CW'(item.c0);
                        work_c_reg[1] <= CW'(item.c1);
                        work_c_reg[2] <= CW'(item.c2);
                        work_tag_reg  <= item.tag;
                        state_reg     <= S_EVAL;
                    end
                end
                S_EVAL:
                begin
                    if (dlv_work)
                    begin
                        // hold the result until the drain shows whether it is last
                        for (int i = 0; i < NUM_PROCS; i++)
                        begin
                            cur_reg[i] <= max_work[i];
                        end
                        pend_tag_reg <= work_tag_reg;
                        pend_fb_reg  <= 1'b0;
                        idx_reg      <= '0;
                        state_reg    <= S_SCAN;
                    end
                    else if (out_free)
                    begin
                        out_tag_reg    <= work_tag_reg;
                        out_status_reg <= has_room ? ST_HELD : ST_DROPPED;
                        out_fb_reg     <= 1'b0;
                        out_last_reg   <= 1'b1;
                        if (has_room)
                        begin
                            cnt_reg <= cnt_reg + CNTW'(1);
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_SCAN:
                begin
                    if (idx_reg == cnt_reg)
                    begin
                        if (out_free)
                        begin
                            out_tag_reg    <= pend_tag_reg;
                            out_status_reg <= ST_DELIVERED;
                            out_fb_reg     <= pend_fb_reg;
                            out_last_reg   <= 1'b1;
                            state_reg      <= S_IDLE;
                        end
                    end
                    else
                    begin
                        state_reg <= S_CHK;
                    end
                end
                S_CHK:
                begin
                    if (dlv_mem)
                    begin
                        if (out_free)
                        begin
                            out_tag_reg    <= pend_tag_reg;
                            out_status_reg <= ST_DELIVERED;
                            out_fb_reg     <= pend_fb_reg;
                            out_last_reg   <= 1'b0;
                            pend_tag_reg   <= mem_tag;
                            pend_fb_reg    <= 1'b1;
                            for (int i = 0; i < NUM_PROCS; i++)
                            begin
                                cur_reg[i] <= max_mem[i];
                            end
                            k_reg     <= idx_reg;
                            state_reg <= S_SHIFT;
                        end
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + CNTW'(1);
                        state_reg <= S_SCAN;
                    end
                end
                S_SHIFT:
                begin
                    // close the gap one entry at a time, then rescan from the oldest
                    if (kp1 == cnt_reg)
                    begin
                        cnt_reg   <= cnt_reg - CNTW'(1);
                        idx_reg   <= '0;
                        state_reg <= S_SCAN;
                    end
                    else
                    begin
                        state_reg <= S_SHW;
                    end
                end
                S_SHW:
                begin
                    k_reg     <= kp1;
                    state_reg <= S_SHIFT;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_tag_reg;
    assign m_axis_tuser  = {out_fb_reg, out_status_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

// ===== src/codb_checker.sv =====
// ----------------------------------------------------------------------------
// codb_checker: port-level checks for the causal-order delivery buffer
// Watches the output stream for consistency of status, source and last.
// ----------------------------------------------------------------------------
module codb_checker
    import codb_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [2:0] m_axis_tuser,
    input logic       m_axis_tlast
);

    // Hold a stalled result: valid and tuser stay
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser[1:0] != ST_UNUSED)
        else $error("unused status code");

    a_buf_delivered: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == ST_DELIVERED)
        else $error("buffered result not a delivery");

    a_held_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[1:0] == ST_HELD || m_axis_tuser[1:0] == ST_DROPPED)
        |-> m_axis_tlast)
        else $error("held or dropped result not last");

endmodule

bind causal_order_delivery_buffer codb_checker u_codb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
